FILE: rtl/fuzzy_subsequence_scorer_defines.svh
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef FUZZY_SUBSEQUENCE_SCORER_DEFINES_SVH
`define FUZZY_SUBSEQUENCE_SCORER_DEFINES_SVH

`ifndef ASSERT_OFF
`define FSS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fss assertion failed");
`define FSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fss assertion failed");
`else
`define FSS_ASSERT(lbl, prop)
`define FSS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/fss_pkg.sv
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer package
// Sizes, operation and register codes, byte classification helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package fss_pkg;

  localparam int QueryMax = 64;
  localparam int QAW      = (QueryMax > 1) ? $clog2(QueryMax) : 1;
  localparam int QLW      = $clog2(QueryMax + 1);
  localparam int ScoreW   = 16;
  localparam int AddW     = 10;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TARGET = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_MATCH_WEIGHT = 2'd0,
    REG_FIRST_BONUS  = 2'd1,
    REG_BOUND_BONUS  = 2'd2,
    REG_CONSEC_BONUS = 2'd3
  } reg_e;

  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChCase  = 8'h20;

  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    fold_byte = (b >= ChUpA && b <= ChUpZ) ? (b | ChCase) : b;
  endfunction

  function automatic logic is_sep(input logic [7:0] b);
    case (b)
      8'h20, 8'h2D, 8'h5F, 8'h2F, 8'h5C, 8'h2E, 8'h3A,
      8'h28, 8'h29, 8'h5B, 8'h5D: is_sep = 1'b1;
      default:                    is_sep = 1'b0;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fuzzy_subsequence_scorer.sv
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer
// Case-insensitive greedy subsequence match of a stored query against a
// streamed target, with weighted bonuses and one result per target.
// ----------------------------------------------------------------------------
// A new input transfer may be accepted every cycle while the input is ready:
// clear, append and target bytes alike. The query sits in a 64-entry byte
// memory with a registered read; the next query byte is fetched from the
// position computed in the same cycle, and an append to that entry is
// bypassed into the read register, so a target byte is matched and scored in
// the cycle it arrives. The result of the target byte marked last is
// registered into the output register or, while that still holds a result,
// into a one-deep skid stage, so input can continue while a result waits;
// input stalls only when both hold a result.
`default_nettype none
`include "fuzzy_subsequence_scorer_defines.svh"

module fuzzy_subsequence_scorer
  import fss_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,

  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [7:0]   cfg_data_i,

  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [1:0]   operation_i,
  input  wire logic [7:0]   data_byte_i,
  input  wire logic         last_i,

  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [ScoreW-1:0] score_o,
  output logic              matched_o
);

  logic [7:0] match_weight_q, first_bonus_q, bound_bonus_q, consec_bonus_q;

  logic [7:0]       mem [QueryMax];
  logic [7:0]       rd_q;
  logic             we;
  logic [QAW-1:0]   waddr;
  logic [QAW-1:0]   raddr;

  logic [QLW-1:0]    len_q, len_d;
  logic [QLW-1:0]    pos_q, pos_d;
  logic [ScoreW-1:0] sum_q, sum_d;
  logic [7:0]        prev_q, prev_d;
  logic              prevm_q, prevm_d;
  logic              start_q, start_d;
  logic              done_q, done_d;

  logic              accept;
  logic              active;
  logic              hit;
  logic [AddW-1:0]   add;
  logic [ScoreW:0]   sum_wide;
  logic              res_new;
  logic [ScoreW-1:0] res_score;
  logic              res_matched;

  logic              out_valid_q, skid_valid_q;
  logic [ScoreW-1:0] out_score_q, skid_score_q;
  logic              out_matched_q, skid_matched_q;
  logic              out_fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !skid_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_weight_q <= 8'd16;
      first_bonus_q  <= 8'd8;
      bound_bonus_q  <= 8'd8;
      consec_bonus_q <= 8'd4;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_e'(cfg_index_i))
        REG_MATCH_WEIGHT: match_weight_q <= cfg_data_i;
        REG_FIRST_BONUS:  first_bonus_q  <= cfg_data_i;
        REG_BOUND_BONUS:  bound_bonus_q  <= cfg_data_i;
        REG_CONSEC_BONUS: consec_bonus_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // rd_q always holds the query byte at pos_q
  always_comb begin
    len_d       = len_q;
    pos_d       = pos_q;
    sum_d       = sum_q;
    prev_d      = prev_q;
    prevm_d     = prevm_q;
    start_d     = start_q;
    done_d      = done_q;
    we          = 1'b0;
    waddr       = len_q[QAW-1:0];
    active      = !done_q && (pos_q < len_q);
    hit         = 1'b0;
    add         = '0;
    sum_wide    = '0;
    res_new     = 1'b0;
    res_score   = '0;
    res_matched = 1'b0;
    if (accept) begin
      unique case (operation_i)
        OP_CLEAR: begin
          len_d   = '0;
          pos_d   = '0;
          sum_d   = '0;
          prev_d  = '0;
          prevm_d = 1'b0;
          start_d = 1'b1;
          done_d  = 1'b0;
        end
        OP_APPEND: begin
          if (len_q < QLW'(QueryMax)) begin
            we    = 1'b1;
            len_d = len_q + QLW'(1);
          end
        end
        OP_TARGET: begin
          hit = active && (fold_byte(data_byte_i) == fold_byte(rd_q));
          if (hit) begin
            add = AddW'(match_weight_q);
            if (start_q) begin
              add = add + AddW'(first_bonus_q);
            end else if (is_sep(prev_q)) begin
              add = add + AddW'(bound_bonus_q);
            end
            if (prevm_q) begin
              add = add + AddW'(consec_bonus_q);
            end
            sum_wide = {1'b0, sum_q} + (ScoreW+1)'(add);
            sum_d    = sum_wide[ScoreW] ? '1 : sum_wide[ScoreW-1:0];
            pos_d    = pos_q + QLW'(1);
            if (pos_d >= len_q) begin
              done_d = 1'b1;
            end
          end
          prevm_d = hit;
          prev_d  = data_byte_i;
          start_d = 1'b0;
          if (last_i) begin
            res_new = 1'b1;
            if (len_q == '0) begin
              res_matched = 1'b1;
            end else if (done_d) begin
              res_score   = sum_d;
              res_matched = 1'b1;
            end
            pos_d   = '0;
            sum_d   = '0;
            prev_d  = '0;
            prevm_d = 1'b0;
            start_d = 1'b1;
            done_d  = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign raddr = pos_d[QAW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= data_byte_i;
    end
    if (we && (waddr == raddr)) begin
      rd_q <= data_byte_i;
    end else begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      pos_q   <= '0;
      sum_q   <= '0;
      prev_q  <= '0;
      prevm_q <= 1'b0;
      start_q <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      len_q   <= len_d;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      prev_q  <= prev_d;
      prevm_q <= prevm_d;
      start_q <= start_d;
      done_q  <= done_d;
    end
  end

  // output register plus one-deep skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (res_new) begin
        if (!out_valid_q || out_fire) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_new) begin
      if (!out_valid_q || out_fire) begin
        out_score_q   <= res_score;
        out_matched_q <= res_matched;
      end else begin
        skid_score_q   <= res_score;
        skid_matched_q <= res_matched;
      end
    end else if (out_fire && skid_valid_q) begin
      out_score_q   <= skid_score_q;
      out_matched_q <= skid_matched_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign score_o     = out_score_q;
  assign matched_o   = out_matched_q;

  `FSS_ASSERT(a_pos_in_query, pos_q <= len_q)
  `FSS_ASSERT(a_done_has_pos, !done_q || (pos_q != '0))
  `FSS_ASSERT(a_skid_behind_out, !skid_valid_q || out_valid_q)
  `FSS_ASSERT_NEXT(a_last_gives_result, accept && operation_i == OP_TARGET && last_i, out_valid_q)
  `FSS_ASSERT(a_nomatch_zero, !(out_valid_o && !matched_o) || (score_o == '0))

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer testbench
// Streams queries and targets through the input channel and writes the score
// weights through the register channel. A transfer-level predictor tracks the
// greedy case-insensitive match and checks every score result in order.
// Random idling on both sides and one long output stall fill the block.
// ----------------------------------------------------------------------------
module testbench
  import fss_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [7:0] LowA = ChUpA | ChCase;
  localparam logic [7:0] LowZ = ChUpZ | ChCase;
  localparam logic [7:0] SepChars [11] = '{8'h20, 8'h2D, 8'h5F, 8'h2F, 8'h5C, 8'h2E,
                                           8'h3A, 8'h28, 8'h29, 8'h5B, 8'h5D};

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic       tail;
  } item_t;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic              matched;
  } score_rec_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i = '0;
  logic [7:0]        cfg_data_i  = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [1:0]        operation_i = '0;
  logic [7:0]        data_byte_i = '0;
  logic              last_i      = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [ScoreW-1:0] score_o;
  logic              matched_o;

  fuzzy_subsequence_scorer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .score_o     (score_o),
    .matched_o   (matched_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // stimulus and expectations
  item_t       pending_items[$];
  score_rec_t  pending_scores[$];
  logic [7:0]  query_text[$];
  int unsigned items_sent      = 0;
  int unsigned error_count     = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_idle_pct   = 0;
  int unsigned hold_left       = 0;

  // shadow registers and match state
  logic [7:0]  weight [4] = '{8'd16, 8'd8, 8'd8, 8'd4};
  logic [7:0]  query_bytes [QueryMax];
  int unsigned query_len      = 0;
  int unsigned query_pos      = 0;
  int unsigned running_score  = 0;
  logic [7:0]  last_target_byte = '0;
  logic        last_was_hit   = 1'b0;
  logic        target_start   = 1'b1;
  logic        query_done     = 1'b0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  function automatic logic [7:0] lower(input logic [7:0] b);
    return (b >= ChUpA && b <= ChUpZ) ? b + (LowA - ChUpA) : b;
  endfunction

  function automatic logic word_break(input logic [7:0] b);
    foreach (SepChars[i]) if (SepChars[i] == b) return 1'b1;
    return 1'b0;
  endfunction

  task automatic begin_new_target();
    query_pos        = 0;
    running_score    = 0;
    last_target_byte = '0;
    last_was_hit     = 1'b0;
    target_start     = 1'b1;
    query_done       = 1'b0;
  endtask

  task automatic advance_match(input logic [1:0] op, input logic [7:0] b, input logic tail);
    int unsigned add;
    logic        hit;
    score_rec_t  res;
    case (op)
      OP_CLEAR: begin
        query_len = 0;
        begin_new_target();
      end
      OP_APPEND: begin
        if (query_len < QueryMax) begin
          query_bytes[query_len] = b;
          query_len++;
        end
      end
      OP_TARGET: begin
        if (!query_done && query_pos < query_len) begin
          hit = lower(b) == lower(query_bytes[query_pos]);
          if (hit) begin
            add = weight[REG_MATCH_WEIGHT];
            if (target_start) add += weight[REG_FIRST_BONUS];
            else if (word_break(last_target_byte)) add += weight[REG_BOUND_BONUS];
            if (last_was_hit) add += weight[REG_CONSEC_BONUS];
            running_score = (running_score + add > 65535) ? 65535 : running_score + add;
            query_pos++;
            if (query_pos >= query_len) query_done = 1'b1;
          end
          last_was_hit = hit;
        end else begin
          last_was_hit = 1'b0;
        end
        last_target_byte = b;
        target_start     = 1'b0;
        if (tail) begin
          res.matched = (query_len == 0) || query_done;
          res.score   = (query_len != 0 && query_done) ? running_score[ScoreW-1:0] : '0;
          pending_scores.push_back(res);
          begin_new_target();
        end
      end
      default: ;
    endcase
  endtask

  // input driver
  always @(posedge clk_i) begin : drive_input
    item_t nxt;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) advance_match(operation_i, data_byte_i, last_i);
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = pending_items.pop_front();
          in_valid_i  <= 1'b1;
          operation_i <= nxt.op;
          data_byte_i <= nxt.data;
          last_i      <= nxt.tail;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long output hold-off
  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // result monitor
  always @(posedge clk_i) begin : watch_output
    score_rec_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_scores.size() == 0) begin
          report_mismatch("unexpected result score", score_o, 0);
        end else begin
          want = pending_scores.pop_front();
          if (score_o !== want.score) report_mismatch("score", score_o, want.score);
          if (matched_o !== want.matched) report_mismatch("matched", matched_o, want.matched);
        end
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_item(input logic [1:0] op, input logic [7:0] b, input logic tail);
    item_t it;
    it.op   = op;
    it.data = b;
    it.tail = tail;
    pending_items.push_back(it);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic write_reg(input reg_e idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    weight[idx] = val;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_weights(input logic [7:0] mw, input logic [7:0] fb,
                             input logic [7:0] bb, input logic [7:0] cb);
    write_reg(REG_MATCH_WEIGHT, mw);
    write_reg(REG_FIRST_BONUS, fb);
    write_reg(REG_BOUND_BONUS, bb);
    write_reg(REG_CONSEC_BONUS, cb);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || pending_scores.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // small alphabet plus separators keeps matches frequent
  function automatic logic [7:0] any_char();
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) return 8'($urandom_range(255));
    if (r < 4) return SepChars[$urandom_range(10)];
    if (r < 8) return LowA + 8'($urandom_range(5));
    if (r < 12) return ChUpA + 8'($urandom_range(5));
    return 8'($urandom_range(8'h7E, 8'h21));
  endfunction

  function automatic logic [7:0] vary_case(input logic [7:0] b);
    if (lower(b) >= LowA && lower(b) <= LowZ && $urandom_range(1) == 1) return b ^ ChCase;
    return b;
  endfunction

  task automatic load_query(input int unsigned n);
    logic [7:0] b;
    push_item(OP_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
    query_text.delete();
    for (int unsigned i = 0; i < n; i++) begin
      b = any_char();
      push_item(OP_APPEND, b, 1'($urandom_range(1)));
      if (query_text.size() < QueryMax) query_text.push_back(b);
    end
  endtask

  task automatic stray_item();
    logic [7:0] b;
    case ($urandom_range(3))
      0: begin
        b = any_char();
        push_item(OP_APPEND, b, 1'($urandom_range(1)));
        if (query_text.size() < QueryMax) query_text.push_back(b);
      end
      1: begin
        push_item(OP_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
        query_text.delete();
      end
      default: push_item(OP_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endcase
  endtask

  // target built around the query, with fillers, case changes and misses
  task automatic send_target(input logic noisy);
    logic [7:0] text[$];
    foreach (query_text[i]) begin
      if ($urandom_range(3) == 0) repeat ($urandom_range(3, 1)) text.push_back(any_char());
      if ($urandom_range(9) == 0) text.push_back(any_char());
      else text.push_back(vary_case(query_text[i]));
    end
    if ($urandom_range(3) == 0) repeat ($urandom_range(3, 1)) text.push_back(any_char());
    if (text.size() == 0) text.push_back(any_char());
    foreach (text[i]) begin
      if (noisy && i > 0 && $urandom_range(19) == 0) stray_item();
      push_item(OP_TARGET, text[i], i == text.size() - 1);
    end
  endtask

  task automatic run_random(input int unsigned goal);
    int unsigned first;
    int unsigned r;
    first = items_sent;
    while (items_sent - first < goal) begin
      r = $urandom_range(99);
      if (r < 6) begin
        load_query(0);
      end else if (r < 8) begin
        load_query($urandom_range(QueryMax + 4, QueryMax - 2));
        send_target(1'b0);
        continue;
      end else begin
        load_query($urandom_range(6, 1));
      end
      repeat ($urandom_range(4, 1)) send_target($urandom_range(3) == 0);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty query, case folding, each bonus, clear and append mid-target
    push_item(OP_TARGET, 8'h71, 1'b1);
    push_item(OP_APPEND, 8'h41, 1'b1);
    push_item(OP_APPEND, 8'h62, 1'b0);
    push_item(OP_UNUSED, 8'hFF, 1'b1);
    push_item(OP_TARGET, 8'h61, 1'b0);
    push_item(OP_TARGET, 8'h42, 1'b0);
    push_item(OP_TARGET, 8'h7A, 1'b1);
    push_item(OP_TARGET, 8'h5F, 1'b0);
    push_item(OP_TARGET, 8'h41, 1'b0);
    push_item(OP_TARGET, 8'h2E, 1'b0);
    push_item(OP_TARGET, 8'h62, 1'b1);
    push_item(OP_TARGET, 8'h00, 1'b0);
    push_item(OP_TARGET, 8'hFF, 1'b1);
    push_item(OP_TARGET, 8'h61, 1'b0);
    push_item(OP_CLEAR, 8'h00, 1'b1);
    push_item(OP_APPEND, 8'h63, 1'b0);
    push_item(OP_TARGET, 8'h43, 1'b0);
    push_item(OP_APPEND, 8'h64, 1'b0);
    push_item(OP_TARGET, 8'h64, 1'b1);
    push_item(OP_TARGET, 8'h5D, 1'b0);
    push_item(OP_TARGET, 8'h63, 1'b0);
    push_item(OP_TARGET, 8'h64, 1'b1);
    wait_drained();

    set_weights(8'd255, 8'd255, 8'd255, 8'd255);
    sender_idle_pct = 34;
    recv_idle_pct   = 79;
    load_query(QueryMax + 3);
    send_target(1'b0);
    run_random(170);
    wait_drained();

    set_weights(8'd0, 8'd0, 8'd0, 8'd0);
    sender_idle_pct = 79;
    recv_idle_pct   = 34;
    run_random(170);
    wait_drained();

    set_weights(8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)), 8'($urandom_range(255)));
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    run_random(170);
    wait_drained();

    // output held off while short targets keep coming
    hold_left <= 300;
    load_query(2);
    repeat (20) send_target(1'b0);
    wait_drained();

    repeat (6) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(4_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
